// ----- rtl/core/cddid_pkg.sv -----
package cddid_pkg;

    localparam int OFFSET_W = 19;
    localparam int SECS_W   = 13;
    localparam int HUND_W   = 7;
    localparam int DSUM_W   = 6;
    localparam int COUNT_W  = 8;
    localparam int CHK_W    = 8;
    localparam int LEN_W    = 16;

    localparam logic [OFFSET_W-1:0] RECIP_75  = 19'd447393;
    localparam int                   SHIFT_75  = 25;
    localparam logic [SECS_W-1:0]    RECIP_100 = 13'd5243;
    localparam int                   SHIFT_100 = 19;

    localparam logic [CHK_W-1:0]     CHECK_MOD = 8'd255;
    localparam logic [COUNT_W-1:0]   COUNT_MAX = 8'd255;

    function automatic logic [4:0] digit_sum_2(input logic [HUND_W-1:0] x);
        logic [3:0]        tens;
        logic [HUND_W-1:0] ones;
        tens = 4'd0;
        for (int t = 1; t < 10; t++) begin
            if (x >= HUND_W'(t * 10)) begin
                tens = 4'(t);
            end
        end
        ones = x - HUND_W'(tens) * HUND_W'(10);
        return 5'(tens) + 5'(ones);
    endfunction

endpackage

// ----- rtl/core/cd_disc_id_generator.sv -----
// The final track's item passes stage registers a, b, c and d; the disc ID then
// appears in the output register. Throughput: one item per cycle; the whole
// pipeline holds while a disc ID waits there and the sink is not ready.
// Reset: synchronous, active low; clears the checksum, first offset, track count
// and all stage valid flags.
module cd_disc_id_generator #(
    parameter int MAX_TRACKS = 99
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // track_offset[18:0], leadout_offset[37:19]
    input  logic        i_s_axis_tlast,   // last_track
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // disc_id[31:0], length_seconds[47:32],
                                          // track_count[55:48]
    output logic        o_m_axis_tuser    // error_flag
);
    import cddid_pkg::*;

    logic w_en;
    logic w_accept;

    logic [OFFSET_W-1:0] w_in_off;
    logic [OFFSET_W-1:0] w_in_lead;
    logic [OFFSET_W-1:0] n_first;
    logic [COUNT_W-1:0]  n_count;

    logic [OFFSET_W-1:0] r_first;
    logic [COUNT_W-1:0]  r_tracks;

    logic                r_a_valid;
    logic [OFFSET_W-1:0] r_a_off;
    logic [OFFSET_W-1:0] r_a_lead;
    logic [OFFSET_W-1:0] r_a_first;
    logic [COUNT_W-1:0]  r_a_count;
    logic                r_a_last;

    logic [2*OFFSET_W-1:0] w_secs_prod;

    logic                r_b_valid;
    logic [SECS_W-1:0]   r_b_secs;
    logic [OFFSET_W-1:0] r_b_diff;
    logic                r_b_err;
    logic [COUNT_W-1:0]  r_b_count;
    logic                r_b_last;

    logic [2*OFFSET_W-1:0] w_len_prod;

    logic                r_c_valid;
    logic [SECS_W-1:0]   r_c_len;
    logic                r_c_err;
    logic [COUNT_W-1:0]  r_c_count;
    logic                r_c_last;

    logic                r_d_valid;
    logic [SECS_W-1:0]   r_d_len;
    logic                r_d_err;
    logic [COUNT_W-1:0]  r_d_count;
    logic                r_d_last;
    logic [DSUM_W-1:0]   w_d_dsum;

    logic [CHK_W:0]      w_chk_sum;
    logic [CHK_W-1:0]    n_chk;
    logic [CHK_W-1:0]    r_chk;

    logic                r_out_valid;
    logic [CHK_W-1:0]    r_out_chk;
    logic [LEN_W-1:0]    r_out_len;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_err;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_accept        = i_s_axis_tvalid && w_en;

    assign w_in_off  = i_s_axis_tdata[OFFSET_W-1:0];
    assign w_in_lead = i_s_axis_tdata[2*OFFSET_W-1:OFFSET_W];
    assign n_first   = (r_tracks == '0) ? w_in_off : r_first;
    assign n_count   = (r_tracks == COUNT_MAX) ? COUNT_MAX : r_tracks + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_tracks <= '0;
        end else if (w_accept) begin
            if (i_s_axis_tlast) begin
                r_first  <= '0;
                r_tracks <= '0;
            end else begin
                r_first  <= n_first;
                r_tracks <= n_count;
            end
        end
    end

    assign w_secs_prod = (2*OFFSET_W)'(r_a_off) * (2*OFFSET_W)'(RECIP_75);
    assign w_len_prod  = (2*OFFSET_W)'(r_b_diff) * (2*OFFSET_W)'(RECIP_75);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_off   <= w_in_off;
            r_a_lead  <= w_in_lead;
            r_a_first <= n_first;
            r_a_count <= n_count;
            r_a_last  <= i_s_axis_tlast;

            r_b_secs  <= w_secs_prod[SHIFT_75 +: SECS_W];
            r_b_diff  <= r_a_lead - r_a_first;
            r_b_err   <= (r_a_lead < r_a_first) || (r_a_count > COUNT_W'(MAX_TRACKS));
            r_b_count <= r_a_count;
            r_b_last  <= r_a_last;

            r_c_len   <= r_b_err ? '0 : w_len_prod[SHIFT_75 +: SECS_W];
            r_c_err   <= r_b_err;
            r_c_count <= r_b_count;
            r_c_last  <= r_b_last;

            r_d_len   <= r_c_len;
            r_d_err   <= r_c_err;
            r_d_count <= r_c_count;
            r_d_last  <= r_c_last;
        end
    end

    cddid_digit_sum u_digit_sum (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_secs (r_b_secs),
        .o_dsum (w_d_dsum)
    );

    assign w_chk_sum = (CHK_W+1)'(r_chk) + (CHK_W+1)'(w_d_dsum);
    assign n_chk     = (w_chk_sum >= (CHK_W+1)'(CHECK_MOD))
                     ? CHK_W'(w_chk_sum - (CHK_W+1)'(CHECK_MOD))
                     : w_chk_sum[CHK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_d_valid && r_d_last;
            if (r_d_valid) begin
                r_chk <= r_d_last ? '0 : n_chk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_d_valid && r_d_last) begin
            r_out_chk   <= n_chk;
            r_out_len   <= LEN_W'(r_d_len);
            r_out_count <= r_d_count;
            r_out_err   <= r_d_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_count, r_out_len, r_out_chk, r_out_len, r_out_count};
    assign o_m_axis_tuser  = r_out_err;

`ifndef SYNTHESIS
    a_no_err_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (r_out_count <= COUNT_W'(MAX_TRACKS)))
        else $error("disc ID without error flag exceeds track limit");

    a_err_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (r_out_len == '0))
        else $error("error flag set with nonzero length");

    a_disc_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tlast) |=> (r_tracks == '0 && r_first == '0))
        else $error("disc state not cleared after final track");

    a_chk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk != CHECK_MOD)
        else $error("checksum out of modulo range");
`endif

endmodule

// ----- rtl/core/cddid_digit_sum.sv -----
module cddid_digit_sum (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [12:0] i_secs,
    output logic [5:0]  o_dsum
);
    import cddid_pkg::*;

    logic [SECS_W-1:0]   r_secs;
    logic [HUND_W-1:0]   r_hund;
    logic [DSUM_W-1:0]   r_dsum;
    logic [2*SECS_W-1:0] w_hund_prod;
    logic [SECS_W-1:0]   w_lo_full;
    logic [DSUM_W-1:0]   n_dsum;

    assign w_hund_prod = (2*SECS_W)'(i_secs) * (2*SECS_W)'(RECIP_100);
    assign w_lo_full   = r_secs - SECS_W'(r_hund) * SECS_W'(100);
    assign n_dsum      = DSUM_W'(digit_sum_2(r_hund))
                       + DSUM_W'(digit_sum_2(w_lo_full[HUND_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_secs <= i_secs;
            r_hund <= w_hund_prod[SHIFT_100 +: HUND_W];
            r_dsum <= n_dsum;
        end
    end

    assign o_dsum = r_dsum;

endmodule
